// File: rtl/core/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: payload structs,
// status codes, controller states and controller/datapath handshake groups.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int OCC_W        = 7;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [OCC_W-1:0]         occupancy;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CMP,
    S_HEAD,
    S_POP,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_head;
    logic rd_prev;
    logic shift;
    logic place;
    logic pop;
    logic set_full;
    logic set_empty;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic idx_zero;
    logic prev_less;
    logic out_free;
  } dp_stat_t;

endpackage : spq_pkg
`default_nettype wire

// File: rtl/core/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller state machine: sequences decode, insertion scan, head read and
// result hand-off for one request at a time.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::dp_stat_t  stat,
  output spq_pkg::ctrl_cmd_t      cmd
);

  spq_pkg::state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = spq_pkg::S_DECODE;
      end
      spq_pkg::S_DECODE: begin
        if (stat.is_remove) begin
          state_nxt = stat.empty ? spq_pkg::S_FIN : spq_pkg::S_HEAD;
        end else begin
          state_nxt = stat.full ? spq_pkg::S_FIN : spq_pkg::S_SCAN;
        end
      end
      spq_pkg::S_SCAN: begin
        state_nxt = stat.idx_zero ? spq_pkg::S_FIN : spq_pkg::S_CMP;
      end
      spq_pkg::S_CMP: begin
        state_nxt = stat.prev_less ? spq_pkg::S_SCAN : spq_pkg::S_FIN;
      end
      spq_pkg::S_HEAD: state_nxt = spq_pkg::S_POP;
      spq_pkg::S_POP:  state_nxt = spq_pkg::S_FIN;
      spq_pkg::S_FIN: begin
        if (stat.out_free) state_nxt = spq_pkg::S_IDLE;
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      spq_pkg::S_DECODE: begin
        cmd.set_full  = !stat.is_remove && stat.full;
        cmd.set_empty = stat.is_remove && stat.empty;
      end
      spq_pkg::S_SCAN: begin
        cmd.place   = stat.idx_zero;
        cmd.rd_prev = !stat.idx_zero;
      end
      spq_pkg::S_CMP: begin
        cmd.shift = stat.prev_less;
        cmd.place = !stat.prev_less;
      end
      spq_pkg::S_HEAD: cmd.rd_head = 1'b1;
      spq_pkg::S_POP:  cmd.pop = 1'b1;
      spq_pkg::S_FIN:  cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule : spq_ctrl
`default_nettype wire

// File: rtl/core/spq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Entry memory kept as a ring (logical slot 0 at the head pointer), request
// latch, scan index, count and the result output register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::in_t       in_data,
  input  wire spq_pkg::ctrl_cmd_t cmd,
  output spq_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spq_pkg::out_t           out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  logic signed [spq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] rdata_r;

  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          op_r;
  logic signed [spq_pkg::DATA_W-1:0] val_r;
  logic [1:0]    status_r, status_nxt;
  logic signed [spq_pkg::DATA_W-1:0] removed_r, removed_nxt;
  logic          out_valid_r, out_valid_nxt;
  spq_pkg::out_t out_r;

  logic [CW-1:0] prev_idx;
  logic [SW-1:0] wsum, rsum;
  logic [AW-1:0] waddr, raddr;
  logic          we, re;
  logic signed [spq_pkg::DATA_W-1:0] wdata;

  // Map logical slots onto the ring
  assign prev_idx = idx_r - CW'(1);
  assign wsum = SW'(base_r) + SW'(idx_r);
  assign rsum = cmd.rd_head ? SW'(base_r) : (SW'(base_r) + SW'(prev_idx));

  always_comb begin
    waddr = (wsum >= CAP_S) ? AW'(wsum - CAP_S) : AW'(wsum);
    raddr = (rsum >= CAP_S) ? AW'(rsum - CAP_S) : AW'(rsum);
  end

  assign we    = cmd.shift || cmd.place;
  assign re    = cmd.rd_prev || cmd.rd_head;
  assign wdata = cmd.shift ? rdata_r : val_r;

  // Entry memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Status toward the controller
  always_comb begin
    stat.is_remove = (op_r == spq_pkg::CMD_REMOVE);
    stat.full      = (count_r == CAP_C);
    stat.empty     = (count_r == '0);
    stat.idx_zero  = (idx_r == '0);
    stat.prev_less = (rdata_r < val_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Next values of control and working registers
  always_comb begin
    base_nxt      = base_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      idx_nxt     = count_r;
      removed_nxt = '0;
    end
    if (cmd.shift) idx_nxt = prev_idx;
    if (cmd.place) begin
      count_nxt  = count_r + CW'(1);
      status_nxt = spq_pkg::ST_INSERTED;
    end
    if (cmd.pop) begin
      base_nxt    = (base_r == LAST_A) ? '0 : base_r + AW'(1);
      count_nxt   = count_r - CW'(1);
      removed_nxt = rdata_r;
      status_nxt  = spq_pkg::ST_REMOVED;
    end
    if (cmd.set_full)  status_nxt = spq_pkg::ST_FULL;
    if (cmd.set_empty) status_nxt = spq_pkg::ST_EMPTY;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (cmd.load) begin
      op_r  <= in_data.cmd;
      val_r <= in_data.value;
    end
    if (cmd.out_load) begin
      out_r.status        <= status_r;
      out_r.removed_value <= removed_r;
      out_r.occupancy     <= spq_pkg::OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Occupancy never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("count above capacity");

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty queue");

  // Place only into a queue with room
  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> (count_r < CAP_C))
    else $error("place into full queue");

  // Never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

endmodule : spq_datapath
`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Max priority queue over a descending sorted array of signed 32-bit values;
// equal values leave first in, first out.
//
//   channel   ports                          direction  payload
//   in        in_valid/in_ready/in_data      input      cmd, value
//   out       out_valid/out_ready/out_data   output     status, removed_value,
//                                                       occupancy
//
// One request at a time. Insert scans up from the tail, with a read and a
// write per moved entry (each stored value smaller than the new one), then
// places it; remove reads the head, then pops it; a refused request (full or
// empty) goes straight to the result. The next request can be taken in the
// cycle after the previous result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass.
// A stalled result waits in the output register; the next request is taken
// while it waits, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire spq_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output spq_pkg::out_t      out_data
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::dp_stat_t  stat;

  // Sequence requests
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store entries and build results
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : sorted_priority_queue
`default_nettype wire
